[design/vie_pkg.sv]
package vie_pkg;

  // Instruction opcodes (upper nibble of the instruction word)
  typedef enum logic [3:0] {
    OPC_LOAD_MEM = 4'h1,
    OPC_LOAD_IMM = 4'h2,
    OPC_STORE    = 4'h3,
    OPC_MOVE     = 4'h4,
    OPC_ADD      = 4'h5,
    OPC_UNFIN_6  = 4'h6,
    OPC_UNFIN_B  = 4'hB,
    OPC_HALT     = 4'hC
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WRONG    = 2'd1,
    ST_NOT_IMPL = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  // Item operation codes
  typedef enum logic {
    OP_EXEC    = 1'b0,
    OP_PRELOAD = 1'b1
  } operation_e;

  localparam int unsigned RegAddrW = 4;
  localparam int unsigned RegDepth = 16;
  localparam int unsigned MemAddrW = 8;
  localparam int unsigned MemDepth = 256;
  localparam int unsigned DataW    = 8;

  localparam logic [MemAddrW-1:0] DisplayAddr = 8'h00;

endpackage

[design/vole_instruction_executor_unit.sv]
// Execute stage register, then output register (registered reads, then execute).
// Throughput: one item per cycle while the output is not stalled; the register
// file and memory reads are registered at the input transfer and written back in
// the execute stage, with a bypass for back-to-back dependent items.
// Reset: register file and halt flag clear; memory reads as zero until written
// (per-byte valid bits cleared by reset, no clearing pass).
module vole_instruction_executor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [15:0] instr_word_i,
  input  logic [7:0] preload_addr_i,
  input  logic [7:0] preload_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic       display_valid_o,
  output logic [7:0] display_value_o,
  output logic       halted_o
);

  localparam int unsigned RAW = vie_pkg::RegAddrW;
  localparam int unsigned MAW = vie_pkg::MemAddrW;
  localparam int unsigned DW  = vie_pkg::DataW;

  // Handshake
  logic s1_vld_q, s1_adv, in_acc, out_acc, out_vld_q;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_vld_q && !out_stall_i;

  // Storage
  logic [DW-1:0] rf_q [vie_pkg::RegDepth];
  logic [DW-1:0] mem [vie_pkg::MemDepth];
  logic [vie_pkg::MemDepth-1:0] mem_vld_q;
  logic halt_q;

  // Execute stage item
  logic          s1_op_q;
  logic [15:0]   s1_word_q;
  logic [MAW-1:0] s1_paddr_q;
  logic [DW-1:0] s1_pdata_q;

  // Registered read data
  logic [DW-1:0] rf_rda_q, rf_rdb_q, mem_rd_q, mem_byp_data_q;
  logic          mem_rd_vld_q, mem_byp_q;

  // Write-back controls of the execute stage
  logic          rf_we, mem_we;
  logic [RAW-1:0] rf_wa;
  logic [MAW-1:0] mem_wa;
  logic [DW-1:0] rf_wd, mem_wd;

  // Read addresses of the incoming item
  logic [RAW-1:0] in_ra_a, in_ra_b;
  logic [MAW-1:0] in_ma;

  assign in_ra_a = (vie_pkg::opcode_e'(instr_word_i[15:12]) == vie_pkg::OPC_STORE) ?
                   instr_word_i[11:8] : instr_word_i[7:4];
  assign in_ra_b = instr_word_i[3:0];
  assign in_ma   = instr_word_i[7:0];

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  // Stage payload and register file reads, bypassing the write in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= operation_i;
      s1_word_q  <= instr_word_i;
      s1_paddr_q <= preload_addr_i;
      s1_pdata_q <= preload_data_i;
      rf_rda_q   <= (rf_we && rf_wa == in_ra_a) ? rf_wd : rf_q[in_ra_a];
      rf_rdb_q   <= (rf_we && rf_wa == in_ra_b) ? rf_wd : rf_q[in_ra_b];
      mem_byp_q      <= mem_we && mem_wa == in_ma;
      mem_byp_data_q <= mem_wd;
      mem_rd_vld_q   <= mem_vld_q[in_ma];
    end
  end

  // Main memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      mem_rd_q <= mem[in_ma];
    end
  end

  // Memory byte valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (mem_we) begin
      mem_vld_q[mem_wa] <= 1'b1;
    end
  end

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vie_pkg::RegDepth; i++) begin
        rf_q[i] <= '0;
      end
    end else if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
  end

  // Execute decode
  vie_pkg::opcode_e opc;
  logic [DW-1:0]    mem_val, byte_xy;
  logic [1:0]       status_d;
  logic             dvalid_d, halt_d;
  logic [DW-1:0]    dvalue_d;

  assign opc     = vie_pkg::opcode_e'(s1_word_q[15:12]);
  assign byte_xy = s1_word_q[7:0];
  assign mem_val = mem_byp_q ? mem_byp_data_q : (mem_rd_vld_q ? mem_rd_q : '0);

  always_comb begin
    rf_we    = 1'b0;
    rf_wa    = s1_word_q[11:8];
    rf_wd    = '0;
    mem_we   = 1'b0;
    mem_wa   = byte_xy;
    mem_wd   = rf_rda_q;
    status_d = vie_pkg::ST_OK;
    dvalid_d = 1'b0;
    dvalue_d = '0;
    halt_d   = halt_q;
    if (s1_op_q == vie_pkg::OP_PRELOAD) begin
      mem_we = s1_adv;
      mem_wa = s1_paddr_q;
      mem_wd = s1_pdata_q;
    end else if (halt_q) begin
      status_d = vie_pkg::ST_IGNORED;
    end else begin
      case (opc)
        vie_pkg::OPC_LOAD_MEM: begin
          rf_we = s1_adv;
          rf_wd = mem_val;
        end
        vie_pkg::OPC_LOAD_IMM: begin
          rf_we = s1_adv;
          rf_wd = byte_xy;
        end
        vie_pkg::OPC_STORE: begin
          mem_we = s1_adv;
          if (byte_xy == vie_pkg::DisplayAddr) begin
            dvalid_d = 1'b1;
            dvalue_d = rf_rda_q;
          end
        end
        vie_pkg::OPC_MOVE: begin
          rf_we = s1_adv;
          rf_wa = s1_word_q[3:0];
          rf_wd = rf_rda_q;
        end
        vie_pkg::OPC_ADD: begin
          rf_we = s1_adv;
          rf_wd = rf_rda_q + rf_rdb_q;
        end
        vie_pkg::OPC_UNFIN_6, vie_pkg::OPC_UNFIN_B: begin
          status_d = vie_pkg::ST_NOT_IMPL;
        end
        vie_pkg::OPC_HALT: begin
          halt_d = 1'b1;
        end
        default: begin
          status_d = vie_pkg::ST_WRONG;
        end
      endcase
    end
  end

  // Halt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_q <= 1'b0;
    end else if (s1_adv) begin
      halt_q <= halt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_acc) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_o        <= status_d;
      display_valid_o <= dvalid_d;
      display_value_o <= dvalue_d;
      halted_o        <= halt_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // Checks
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(halt_q))
    else $error("halt flag cleared");

  a_ignored_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == vie_pkg::ST_IGNORED |-> halted_o)
    else $error("ignored status without halt");

  a_display_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_valid_o |-> status_o == vie_pkg::ST_OK)
    else $error("display with bad status");

  a_display_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !display_valid_o |-> display_value_o == '0)
    else $error("display value without display");

endmodule
